>>> hdl/frame_presentation_scheduler_unit_macros.svh
// Assertion macros shared by the frame presentation scheduler modules.
// Each macro expands to one labeled concurrent assertion on a given clock and reset.
`ifndef FRAME_PRESENTATION_SCHEDULER_UNIT_MACROS_SVH
`define FRAME_PRESENTATION_SCHEDULER_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define FPS_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fps assertion failed");

// Antecedent in one cycle implies consequent in the next
`define FPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fps assertion failed");

`endif

>>> hdl/fps_pkg.sv
// Shared types, codes and helper functions for the frame presentation scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
package fps_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int SLOT_W     = 4;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int LIMIT_W    = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

    // Input opcodes
    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_RENDER   = 3'd0;
    localparam logic [2:0] KIND_SKIP     = 3'd1;
    localparam logic [2:0] KIND_STATUS   = 3'd2;
    localparam logic [2:0] KIND_FILL_OK  = 3'd3;
    localparam logic [2:0] KIND_FILL_REF = 3'd4;
    localparam logic [2:0] KIND_FLUSHED  = 3'd5;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] event_time;
        logic              audio_resync;
        logic              stream_ended;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] time_value;
        logic              time_pending;
        logic              end_of_stream;
        logic [CNT_W-1:0]  behind_count;
        logic [TIME_W-1:0] behind_worst;
        logic [CNT_W-1:0]  skipped_total;
        logic [CNT_W-1:0]  played_total;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FLUSH,
        ST_WALK_RD,
        ST_WALK_EVAL,
        ST_WALK_NEXT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic fill;
        logic flush;
        logic read;
        logic consume;
        logic emit_status;
        logic emit_frame;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic walk_stop;
    } status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    // Ring index as reported in the slot field (low bits)
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, i};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

>>> hdl/frame_presentation_scheduler_unit.sv
// Top level of the frame presentation scheduler: controller plus datapath.
// Depends on fps_pkg, fps_ctrl and fps_dp.

// Frame presentation scheduler. Items enter on in_valid/in_stall and results
// leave on out_valid/out_stall; one item is worked on at a time, and a new
// item is taken while the previous result still sits in the output register.
// A fill or flush gives one result, once the output register is free. A tick
// walks the ring frame by frame, each slot time coming from the timestamp
// memory through its single registered read port; render/skip results carry
// last = 0, and the closing tick status carries last = 1. Opcode 3 is
// dropped with no result. resync_limit is to be written through
// cfg_wr_en/cfg_wr_data only while the block is idle (the block itself does
// not enforce this) and resets to 1000 ms.
module frame_presentation_scheduler_unit
    import fps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_item,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    fps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_item.opcode),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Ring, statistics and output register
    fps_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

>>> hdl/fps_ctrl.sv
// Sequencer for the frame presentation scheduler: input handshake and walk control.
// Depends on fps_pkg and the shared assertion macro header.
`include "frame_presentation_scheduler_unit_macros.svh"

module fps_ctrl
    import fps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_opcode,
    output logic       in_stall,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_opcode)
                        OP_FILL:  state_next = ST_FILL;
                        OP_TICK:  state_next = ST_WALK_RD;
                        OP_FLUSH: state_next = ST_FLUSH;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL, ST_FLUSH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_EVAL;
            end
            ST_WALK_EVAL:
            begin
                if (status.out_free)
                    state_next = status.walk_stop ? ST_IDLE : ST_WALK_NEXT;
            end
            ST_WALK_NEXT:
            begin
                if (status.out_free)
                    state_next = ST_WALK_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_FILL:
            begin
                cmd.fill = status.out_free;
            end
            ST_FLUSH:
            begin
                cmd.flush = status.out_free;
            end
            ST_WALK_RD:
            begin
                cmd.read = 1'b1;
            end
            ST_WALK_EVAL:
            begin
                cmd.emit_status = status.out_free && status.walk_stop;
                cmd.consume     = status.out_free && !status.walk_stop;
            end
            ST_WALK_NEXT:
            begin
                cmd.emit_frame = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // At most one datapath action per cycle
    `FPS_ASSERT_ALWAYS(a_one_cmd, clk, rst_n,
        $onehot0({cmd.capture, cmd.fill, cmd.flush, cmd.read, cmd.consume,
                  cmd.emit_status, cmd.emit_frame}))
    // A consumed frame is always followed by its render or skip result before the next step
    `FPS_ASSERT_NEXT(a_consume_then_emit, clk, rst_n, cmd.consume,
        (!cmd.consume && !cmd.emit_status))
    // The final status of a tick returns the block to accepting items
    `FPS_ASSERT_NEXT(a_status_ends_walk, clk, rst_n, cmd.emit_status, !in_stall)

endmodule

>>> hdl/fps_dp.sv
// Datapath of the frame presentation scheduler: slot flags, timestamp memory,
// pointers, statistics and the output register. Depends on fps_pkg and the macro header.
`include "frame_presentation_scheduler_unit_macros.svh"

module fps_dp
    import fps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  in_item_t           in_item,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_item
);

    // Timestamp store, no reset: its data is only used behind a set flag
    logic [TIME_W-1:0] mem [RING_DEPTH];

    logic [RING_DEPTH-1:0] full_reg,      full_next;
    logic [IDX_W-1:0]      fill_ptr_reg,  fill_ptr_next;
    logic [IDX_W-1:0]      play_ptr_reg,  play_ptr_next;
    logic [LIMIT_W-1:0]    limit_reg;
    in_item_t              req_reg;
    logic [TIME_W-1:0]     rd_data_reg;
    logic [TIME_W-1:0]     cur_ft_reg;
    logic [IDX_W-1:0]      cur_slot_reg;
    logic [CNT_W-1:0]      late_frames_reg, late_frames_next;
    logic [TIME_W-1:0]     late_max_reg,    late_max_next;
    logic [CNT_W-1:0]      skip_reg,        skip_next;
    logic [CNT_W-1:0]      play_reg,        play_next;
    logic                  out_valid_reg;
    out_item_t             out_item_reg,    out_item_next;

    logic [IDX_W-1:0]  nx_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              full_p;
    logic              full_f;
    logic              is_future;
    logic              is_late;
    logic [TIME_W-1:0] behind;
    logic              too_late;
    logic              slot_empty;
    logic              emit_any;

    // Compare the fetched frame time against the tick time
    always_comb
    begin
        nx_idx     = next_idx(play_ptr_reg);
        full_p     = full_reg[play_ptr_reg];
        full_f     = full_reg[fill_ptr_reg];
        is_future  = rd_data_reg > req_reg.event_time;
        is_late    = rd_data_reg < req_reg.event_time;
        behind     = req_reg.event_time - rd_data_reg;
        too_late   = req_reg.audio_resync && is_late && (behind > TIME_W'(limit_reg));
        slot_empty = !full_p;
        rd_addr    = cmd.consume ? nx_idx : play_ptr_reg;
    end

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.walk_stop = slot_empty || is_future || too_late;

    // Ring and statistics update
    always_comb
    begin
        full_next        = full_reg;
        fill_ptr_next    = fill_ptr_reg;
        play_ptr_next    = play_ptr_reg;
        late_frames_next = late_frames_reg;
        late_max_next    = late_max_reg;
        skip_next        = skip_reg;
        play_next        = play_reg;

        if (cmd.fill && !full_f)
        begin
            full_next[fill_ptr_reg] = 1'b1;
            fill_ptr_next           = next_idx(fill_ptr_reg);
        end
        if (cmd.flush)
        begin
            full_next     = '0;
            fill_ptr_next = '0;
            play_ptr_next = '0;
        end
        if (cmd.consume)
        begin
            full_next[play_ptr_reg] = 1'b0;
            play_ptr_next           = nx_idx;
            play_next               = sat_inc(play_reg);
            if (is_late)
            begin
                late_frames_next = sat_inc(late_frames_reg);
                if (behind > late_max_reg)
                    late_max_next = behind;
            end
        end
        // rd_data now holds the following slot's time: skip if it is due too
        if (cmd.emit_frame && full_p && !is_future)
            skip_next = sat_inc(skip_reg);
    end

    // Result formatting
    always_comb
    begin
        out_item_next                = '0;
        out_item_next.behind_count   = late_frames_next;
        out_item_next.behind_worst   = late_max_next;
        out_item_next.skipped_total  = skip_next;
        out_item_next.played_total   = play_next;
        out_item_next.last           = 1'b1;
        if (cmd.fill)
        begin
            out_item_next.kind       = full_f ? KIND_FILL_REF : KIND_FILL_OK;
            out_item_next.slot       = slot_of(fill_ptr_reg);
            out_item_next.time_value = req_reg.event_time;
        end
        else if (cmd.flush)
        begin
            out_item_next.kind = KIND_FLUSHED;
        end
        else if (cmd.emit_status)
        begin
            out_item_next.kind          = KIND_STATUS;
            out_item_next.time_value    = slot_empty ? '0 : rd_data_reg;
            out_item_next.time_pending  = !slot_empty;
            out_item_next.end_of_stream = slot_empty && req_reg.stream_ended;
        end
        else
        begin
            out_item_next.kind       = (full_p && !is_future) ? KIND_SKIP : KIND_RENDER;
            out_item_next.slot       = slot_of(cur_slot_reg);
            out_item_next.time_value = cur_ft_reg;
            out_item_next.last       = 1'b0;
        end
    end

    assign emit_any = cmd.fill || cmd.flush || cmd.emit_status || cmd.emit_frame;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg        <= '0;
            fill_ptr_reg    <= '0;
            play_ptr_reg    <= '0;
            limit_reg       <= LIMIT_RESET;
            late_frames_reg <= '0;
            late_max_reg    <= '0;
            skip_reg        <= '0;
            play_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            full_reg        <= full_next;
            fill_ptr_reg    <= fill_ptr_next;
            play_ptr_reg    <= play_ptr_next;
            late_frames_reg <= late_frames_next;
            late_max_reg    <= late_max_next;
            skip_reg        <= skip_next;
            play_reg        <= play_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (emit_any)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_item;
        if (cmd.consume)
        begin
            cur_ft_reg   <= rd_data_reg;
            cur_slot_reg <= play_ptr_reg;
        end
        if (emit_any)
            out_item_reg <= out_item_next;
    end

    // Timestamp memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.fill && !full_f)
            mem[fill_ptr_reg] <= req_reg.event_time;
        if (cmd.read || cmd.consume)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Pointers stay inside the ring
    `FPS_ASSERT_ALWAYS(a_ptr_range, clk, rst_n,
        (fill_ptr_reg <= IDX_W'(RING_DEPTH - 1)) && (play_ptr_reg <= IDX_W'(RING_DEPTH - 1)))
    // A flush empties the ring and rewinds both pointers
    `FPS_ASSERT_NEXT(a_flush_clears, clk, rst_n, cmd.flush,
        (full_reg == '0) && (fill_ptr_reg == '0) && (play_ptr_reg == '0))
    // Every skipped frame was also consumed
    `FPS_ASSERT_ALWAYS(a_skip_le_play, clk, rst_n, skip_reg <= play_reg)

endmodule

>>> tb/frame_presentation_scheduler_checker.sv
// Checker for the frame presentation scheduler: watches both item channels and the
// config port, keeps its own copy of the frame ring and compares every result item.
// Depends on fps_pkg for the item types, widths and codes.
module fps_presentation_checker
    import fps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_item_t           in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_item_t          out_item,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    output int                 mismatches,
    output int                 outstanding
);

    // Shadow of the ring and the statistics
    logic               ring_full [RING_DEPTH];
    logic [TIME_W-1:0]  ring_time [RING_DEPTH];
    logic [IDX_W-1:0]   wr_ptr;
    logic [IDX_W-1:0]   rd_ptr;
    logic [CNT_W-1:0]   n_late;
    logic [CNT_W-1:0]   n_skip;
    logic [CNT_W-1:0]   n_play;
    logic [TIME_W-1:0]  worst_late;
    logic [LIMIT_W-1:0] limit;

    // Result items predicted but not yet seen, oldest first
    out_item_t sched_q [$];
    out_item_t head;
    int        err_cnt;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    // Queue one result item carrying the statistics as they stand now
    task automatic post(input logic [2:0] kind, input logic [IDX_W-1:0] slot,
                        input logic [TIME_W-1:0] tv, input logic hnt, input logic eos,
                        input logic fin);
        out_item_t r;
        r.kind           = kind;
        r.slot           = SLOT_W'(slot);
        r.time_value     = tv;
        r.time_pending   = hnt;
        r.end_of_stream  = eos;
        r.behind_count   = n_late;
        r.behind_worst   = worst_late;
        r.skipped_total  = n_skip;
        r.played_total   = n_play;
        r.last           = fin;
        sched_q.push_back(r);
    endtask

    // Apply one accepted item to the shadow ring
    task automatic run_schedule(input in_item_t it);
        logic [IDX_W-1:0]  p;
        logic [IDX_W-1:0]  nx;
        logic [TIME_W-1:0] ft;
        logic [TIME_W-1:0] lag;
        logic              done;
        case (it.opcode)
            OP_FILL:
            begin
                if (ring_full[wr_ptr])
                begin
                    post(KIND_FILL_REF, wr_ptr, it.event_time, 1'b0, 1'b0, 1'b1);
                end
                else
                begin
                    ring_time[wr_ptr] = it.event_time;
                    ring_full[wr_ptr] = 1'b1;
                    post(KIND_FILL_OK, wr_ptr, it.event_time, 1'b0, 1'b0, 1'b1);
                    wr_ptr = wrap_next(wr_ptr);
                end
            end
            OP_FLUSH:
            begin
                for (int i = 0; i < RING_DEPTH; i++)
                    ring_full[i] = 1'b0;
                wr_ptr = '0;
                rd_ptr = '0;
                post(KIND_FLUSHED, '0, '0, 1'b0, 1'b0, 1'b1);
            end
            OP_TICK:
            begin
                done = 1'b0;
                // walk from the play pointer until an empty, future or held frame
                for (int g = 0; g <= RING_DEPTH && !done; g++)
                begin
                    p = rd_ptr;
                    ft = ring_time[p];
                    lag = it.event_time - ft;
                    if (!ring_full[p])
                    begin
                        post(KIND_STATUS, '0, '0, 1'b0, it.stream_ended, 1'b1);
                        done = 1'b1;
                    end
                    else if (ft > it.event_time ||
                             (ft < it.event_time && it.audio_resync &&
                              lag > TIME_W'(limit)))
                    begin
                        post(KIND_STATUS, '0, ft, 1'b1, 1'b0, 1'b1);
                        done = 1'b1;
                    end
                    else
                    begin
                        if (ft < it.event_time)
                        begin
                            n_late = bump(n_late);
                            if (lag > worst_late)
                                worst_late = lag;
                        end
                        ring_full[p] = 1'b0;
                        nx = wrap_next(p);
                        rd_ptr = nx;
                        n_play = bump(n_play);
                        // skip when the following frame is due as well
                        if (!ring_full[nx] || ring_time[nx] > it.event_time)
                        begin
                            post(KIND_RENDER, p, ft, 1'b0, 1'b0, 1'b0);
                        end
                        else
                        begin
                            n_skip = bump(n_skip);
                            post(KIND_SKIP, p, ft, 1'b0, 1'b0, 1'b0);
                        end
                    end
                end
                if (!done)
                    post(KIND_STATUS, '0, '0, 1'b0, it.stream_ended, 1'b1);
            end
            default:
            begin
                // spare opcode: dropped, no result
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Outputs first, then the new item: a result never leaves in its item's cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_full[i] = 1'b0;
                ring_time[i] = '0;
            end
            wr_ptr = '0;
            rd_ptr = '0;
            n_late = '0;
            n_skip = '0;
            n_play = '0;
            worst_late = '0;
            limit = LIMIT_RESET;
            sched_q.delete();
            err_cnt = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                limit = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (sched_q.size() == 0)
                begin
                    $display("%0t: result mismatch: expected none, actual %0h",
                             $time, out_item);
                    err_cnt++;
                end
                else
                begin
                    head = sched_q.pop_front();
                    check_field("kind", 64'(head.kind), 64'(out_item.kind));
                    check_field("slot", 64'(head.slot), 64'(out_item.slot));
                    check_field("time_value", 64'(head.time_value), 64'(out_item.time_value));
                    check_field("time_pending", 64'(head.time_pending),
                                64'(out_item.time_pending));
                    check_field("end_of_stream", 64'(head.end_of_stream),
                                64'(out_item.end_of_stream));
                    check_field("behind_count", 64'(head.behind_count),
                                64'(out_item.behind_count));
                    check_field("behind_worst", 64'(head.behind_worst),
                                64'(out_item.behind_worst));
                    check_field("skipped_total", 64'(head.skipped_total),
                                64'(out_item.skipped_total));
                    check_field("played_total", 64'(head.played_total),
                                64'(out_item.played_total));
                    check_field("last", 64'(head.last), 64'(out_item.last));
                end
            end
            if (in_valid && !in_stall)
                run_schedule(in_item);
            outstanding <= sched_q.size();
            mismatches <= err_cnt;
        end
    end

endmodule

>>> tb/frame_presentation_scheduler_unit_tb.sv
// Testbench top for the frame presentation scheduler: clock, reset, item stimulus,
// output stall pattern, watchdog and verdict. Depends on fps_pkg, the block and
// fps_presentation_checker.
module frame_presentation_scheduler_unit_tb
    import fps_pkg::*;
();

    localparam logic [1:0]        OP_SPARE     = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam int                DRAIN_CYCLES = 3 + 2 * RING_DEPTH + 8;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                IDLE_LIMIT   = 5000;
    localparam int                PHASE_ITEMS  = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    in_item_t           in_item = '0;
    logic               out_stall = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               in_stall;
    logic               out_valid;
    out_item_t          out_item;
    int                 mismatches;
    int                 outstanding;

    logic              hold_go = 1'b0;
    int                hold_cnt = 0;
    int                burst_left = 0;
    int                idle_cycles = 0;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] frame_ms;

    frame_presentation_scheduler_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    fps_presentation_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic in_item_t mk(input logic [1:0] op, input logic [TIME_W-1:0] t,
                                    input logic rs, input logic en);
        in_item_t it;
        it.opcode       = op;
        it.event_time   = t;
        it.audio_resync = rs;
        it.stream_ended = en;
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    // Offer one item and hold it until accepted; bursts are split by random gaps
    task automatic offer(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(20, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drain every predicted result, then let a dropped spare item finish
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: stall pattern of its own, plus one long hold-off once requested
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt++;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no item accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("frame_presentation_scheduler_unit test failed");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        in_item_t           it;
        int                 count;
        int                 pick;
        int                 fill_pct;
        logic               rs;
        logic               en;
        logic [LIMIT_W-1:0] limits [4];

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit of 1000 ms
        offer(mk(OP_TICK, '0, 1'b0, 1'b0));           // empty ring, stream running
        offer(mk(OP_SPARE, TIME_MAX, 1'b1, 1'b1));    // spare opcode, dropped
        offer(mk(OP_FILL, 48'd100, 1'b0, 1'b0));
        offer(mk(OP_FILL, 48'd300, 1'b0, 1'b0));
        offer(mk(OP_TICK, 48'd100, 1'b0, 1'b0));      // on time, then future frame
        offer(mk(OP_FILL, '0, 1'b0, 1'b0));
        offer(mk(OP_TICK, TIME_MAX, 1'b1, 1'b0));     // too late under resync: held
        offer(mk(OP_TICK, TIME_MAX, 1'b0, 1'b1));     // late skip, render, end of stream
        offer(mk(OP_FILL, '0, 1'b0, 1'b0));
        offer(mk(OP_TICK, 48'd1000, 1'b1, 1'b0));     // late by exactly the limit
        offer(mk(OP_FLUSH, TIME_MAX, 1'b1, 1'b1));
        for (int i = 0; i < RING_DEPTH; i++)
            offer(mk(OP_FILL, TIME_W'(i * 7), 1'b0, 1'b0));
        offer(mk(OP_FILL, TIME_MAX, 1'b0, 1'b0));     // ring full: refused
        offer(mk(OP_TICK, TIME_W'((RING_DEPTH - 1) * 7), 1'b0, 1'b0));  // whole ring due

        limits[0] = '0;
        limits[1] = '1;
        limits[2] = LIMIT_W'($urandom_range(1, 65534));
        limits[3] = LIMIT_W'($urandom_range(1, 200));

        // Random phases, one per resync limit
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            write_limit(limits[ph]);
            now_ms = rand_time() >> $urandom_range(0, 47);
            if (now_ms > TIME_MAX - 48'h1_0000_0000)
                now_ms = now_ms - 48'h1_0000_0000;
            frame_ms = now_ms + $urandom_range(0, 100);
            fill_pct = $urandom_range(35, 60);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if (ph == 0 && count == 20)
                    hold_go <= 1'b1;
                pick = $urandom_range(0, 99);
                rs = ($urandom_range(0, 3) == 0);
                en = ($urandom_range(0, 3) == 0);
                if (pick < fill_pct)
                begin
                    it = mk(OP_FILL, frame_ms, rs, en);
                    frame_ms = frame_ms + $urandom_range(20, 50);
                end
                else if (pick < 85)
                begin
                    now_ms = now_ms + $urandom_range(0, 80);
                    if ($urandom_range(0, 9) == 0)
                        now_ms = now_ms + $urandom_range(0, 4000);
                    // keep the decoder close behind the clock
                    if (frame_ms + 200 < now_ms)
                        frame_ms = now_ms + $urandom_range(0, 100);
                    it = mk(OP_TICK, now_ms, rs, en);
                end
                else if (pick < 90)
                    it = mk(($urandom_range(0, 1) == 1) ? OP_TICK : OP_FILL,
                            rand_time(), rs, en);
                else if (pick < 93)
                    it = mk(OP_FLUSH, rand_time(), rs, en);
                else if (pick < 96)
                    it = mk(OP_SPARE, rand_time(), rs, en);
                else
                    it = mk(OP_TICK, now_ms - $urandom_range(0, 300), rs, en);
                offer(it);
                if (it.opcode != OP_SPARE)
                    count++;
            end
        end

        settle();
        if (mismatches == 0)
            $display("frame_presentation_scheduler_unit test passed");
        else
            $display("frame_presentation_scheduler_unit test failed");
        $finish;
    end

endmodule
